// ----- sv/tpe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_pkg
// types, codes and helpers shared by the passive tcp endpoint
// ----------------------------------------------------------------------------
package tpe_pkg;

	localparam int unsigned SEQ_W  = 32;
	localparam int unsigned PORT_W = 16;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned FLAG_W = 8;
	localparam int unsigned CFG_W  = 32;
	localparam int unsigned CODE_W = 3;

	// tcp flag bits
	localparam logic [FLAG_W-1:0] FLAG_FIN = 8'h01;
	localparam logic [FLAG_W-1:0] FLAG_SYN = 8'h02;
	localparam logic [FLAG_W-1:0] FLAG_PSH = 8'h08;
	localparam logic [FLAG_W-1:0] FLAG_ACK = 8'h10;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_INITIAL_SEND_SEQ = 1'b0,
		CFG_LOCAL_PORT       = 1'b1
	} tpe_cfg_idx_t;

	typedef enum logic [1:0] {
		OP_LISTEN  = 2'd0,
		OP_SEGMENT = 2'd1,
		OP_WRITE   = 2'd2,
		OP_CLOSE   = 2'd3
	} tpe_op_t;

	// connection phase, one-hot
	typedef enum logic [5:0] {
		PH_CLOSED     = 6'b000001,
		PH_LISTEN     = 6'b000010,
		PH_SYN_RCVD   = 6'b000100,
		PH_ESTAB      = 6'b001000,
		PH_CLOSE_WAIT = 6'b010000,
		PH_LAST_ACK   = 6'b100000
	} tpe_phase_t;

	// reported state codes
	localparam logic [CODE_W-1:0] CODE_CLOSED     = 3'd0;
	localparam logic [CODE_W-1:0] CODE_LISTEN     = 3'd1;
	localparam logic [CODE_W-1:0] CODE_SYN_RCVD   = 3'd2;
	localparam logic [CODE_W-1:0] CODE_ESTAB      = 3'd3;
	localparam logic [CODE_W-1:0] CODE_CLOSE_WAIT = 3'd4;
	localparam logic [CODE_W-1:0] CODE_LAST_ACK   = 3'd5;

	typedef struct packed {
		tpe_op_t            op;
		logic [FLAG_W-1:0]  seg_flags;
		logic [SEQ_W-1:0]   seg_seq;
		logic [SEQ_W-1:0]   seg_ack;
		logic [LEN_W-1:0]   payload_len;
		logic [PORT_W-1:0]  peer_port;
		logic [ADDR_W-1:0]  peer_addr;
	} tpe_req_t;

	typedef struct packed {
		logic               status;
		logic               send;
		logic [FLAG_W-1:0]  tx_flags;
		logic [SEQ_W-1:0]   tx_seq;
		logic [SEQ_W-1:0]   tx_ack;
		logic [PORT_W-1:0]  tx_src_port;
		logic [PORT_W-1:0]  tx_dst_port;
		logic [ADDR_W-1:0]  tx_dst_addr;
		logic [LEN_W-1:0]   tx_payload_len;
		logic               rx_accept;
		logic [CODE_W-1:0]  conn_state;
	} tpe_rsp_t;

	function automatic logic [CODE_W-1:0] phase_code(input tpe_phase_t ph);
		logic [CODE_W-1:0] code;
		unique case (ph)
			PH_LISTEN:     code = CODE_LISTEN;
			PH_SYN_RCVD:   code = CODE_SYN_RCVD;
			PH_ESTAB:      code = CODE_ESTAB;
			PH_CLOSE_WAIT: code = CODE_CLOSE_WAIT;
			PH_LAST_ACK:   code = CODE_LAST_ACK;
			default:       code = CODE_CLOSED;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

// ----- sv/tpe_conn.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tpe_conn
// connection state registers and the per-transfer update logic
// ----------------------------------------------------------------------------
module tpe_conn (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step_en,
	input  wire tpe_pkg::tpe_req_t             item,
	input  wire logic [tpe_pkg::SEQ_W-1:0]     initial_send_seq,
	input  wire logic [tpe_pkg::PORT_W-1:0]    src_port,
	output tpe_pkg::tpe_rsp_t                  result
);

	tpe_pkg::tpe_phase_t               phase_q, phase_d;
	logic [tpe_pkg::SEQ_W-1:0]         send_next_q, send_next_d;
	logic [tpe_pkg::SEQ_W-1:0]         recv_next_q, recv_next_d;
	logic [tpe_pkg::PORT_W-1:0]        remote_port_q, remote_port_d;
	logic [tpe_pkg::ADDR_W-1:0]        remote_addr_q, remote_addr_d;

	logic                              emit;
	logic [tpe_pkg::FLAG_W-1:0]        emit_flags;
	logic [tpe_pkg::SEQ_W-1:0]         emit_seq;
	logic [tpe_pkg::LEN_W-1:0]         emit_len;
	logic                              status;
	logic                              rx_accept;
	logic                              has_fin, has_syn, has_ack;
	logic                              seq_match;

	assign has_fin   = |(item.seg_flags & tpe_pkg::FLAG_FIN);
	assign has_syn   = |(item.seg_flags & tpe_pkg::FLAG_SYN);
	assign has_ack   = |(item.seg_flags & tpe_pkg::FLAG_ACK);
	assign seq_match = (item.seg_seq == recv_next_q);

	always_comb begin
		phase_d       = phase_q;
		send_next_d   = send_next_q;
		recv_next_d   = recv_next_q;
		remote_port_d = remote_port_q;
		remote_addr_d = remote_addr_q;
		emit          = 1'b0;
		emit_flags    = '0;
		emit_seq      = '0;
		emit_len      = '0;
		status        = 1'b0;
		rx_accept     = 1'b0;
		unique case (item.op)
			tpe_pkg::OP_LISTEN: begin
				unique case (phase_q) inside
					tpe_pkg::PH_LISTEN, tpe_pkg::PH_SYN_RCVD, tpe_pkg::PH_ESTAB,
					tpe_pkg::PH_CLOSE_WAIT, tpe_pkg::PH_LAST_ACK: begin
						status = 1'b1;
					end
					default: begin
						phase_d = tpe_pkg::PH_LISTEN;
					end
				endcase
			end
			tpe_pkg::OP_SEGMENT: begin
				unique case (phase_q)
					tpe_pkg::PH_LISTEN: begin
						if (has_syn && !has_ack) begin
							remote_port_d = item.peer_port;
							remote_addr_d = item.peer_addr;
							recv_next_d   = item.seg_seq + 32'd1;
							send_next_d   = initial_send_seq + 32'd1;
							emit          = 1'b1;
							emit_flags    = tpe_pkg::FLAG_SYN | tpe_pkg::FLAG_ACK;
							emit_seq      = initial_send_seq;
							phase_d       = tpe_pkg::PH_SYN_RCVD;
						end
					end
					tpe_pkg::PH_SYN_RCVD: begin
						if (has_ack && item.seg_ack == send_next_q) begin
							phase_d = tpe_pkg::PH_ESTAB;
						end
					end
					tpe_pkg::PH_ESTAB: begin
						if (has_fin) begin
							if (seq_match) begin
								recv_next_d = recv_next_q + 32'd1;
								emit        = 1'b1;
								emit_flags  = tpe_pkg::FLAG_ACK;
								emit_seq    = send_next_q;
								phase_d     = tpe_pkg::PH_CLOSE_WAIT;
							end
						end else if (item.payload_len != '0 && seq_match) begin
							recv_next_d = recv_next_q + {16'd0, item.payload_len};
							rx_accept   = 1'b1;
							emit        = 1'b1;
							emit_flags  = tpe_pkg::FLAG_ACK;
							emit_seq    = send_next_q;
						end
					end
					tpe_pkg::PH_LAST_ACK: begin
						if (has_ack) begin
							phase_d = tpe_pkg::PH_CLOSED;
						end
					end
					default: begin
					end
				endcase
			end
			tpe_pkg::OP_WRITE: begin
				if (phase_q == tpe_pkg::PH_ESTAB) begin
					emit        = 1'b1;
					emit_flags  = tpe_pkg::FLAG_ACK | tpe_pkg::FLAG_PSH;
					emit_seq    = send_next_q;
					emit_len    = item.payload_len;
					send_next_d = send_next_q + {16'd0, item.payload_len};
				end else begin
					status = 1'b1;
				end
			end
			default: begin
				if (phase_q == tpe_pkg::PH_ESTAB || phase_q == tpe_pkg::PH_CLOSE_WAIT) begin
					emit        = 1'b1;
					emit_flags  = tpe_pkg::FLAG_FIN | tpe_pkg::FLAG_ACK;
					emit_seq    = send_next_q;
					send_next_d = send_next_q + 32'd1;
					phase_d     = tpe_pkg::PH_LAST_ACK;
				end
			end
		endcase
	end

	// header fields read the updated peer and receive state; zero when silent
	always_comb begin
		result                = '0;
		result.status         = status;
		result.rx_accept      = rx_accept;
		result.conn_state     = tpe_pkg::phase_code(phase_d);
		if (emit) begin
			result.send           = 1'b1;
			result.tx_flags       = emit_flags;
			result.tx_seq         = emit_seq;
			result.tx_ack         = recv_next_d;
			result.tx_src_port    = src_port;
			result.tx_dst_port    = remote_port_d;
			result.tx_dst_addr    = remote_addr_d;
			result.tx_payload_len = emit_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= tpe_pkg::PH_CLOSED;
			send_next_q   <= '0;
			recv_next_q   <= '0;
			remote_port_q <= '0;
			remote_addr_q <= '0;
		end else if (step_en) begin
			phase_q       <= phase_d;
			send_next_q   <= send_next_d;
			recv_next_q   <= recv_next_d;
			remote_port_q <= remote_port_d;
			remote_addr_q <= remote_addr_d;
		end
	end

endmodule
`default_nettype wire

// ----- sv/tcp_passive_endpoint_fsm.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tcp_passive_endpoint_fsm
// single tcp endpoint with passive open, in-order receive and fin close
// ----------------------------------------------------------------------------
// Each request transfer (listen, parsed received segment, application write or
// close) yields exactly one response transfer carrying the header of the
// segment to send, if any, the receive accept flag, a reject status and the
// connection state after the update. A request is registered in the input
// register, then the state update and response are computed combinationally
// and captured in the response register, so the block sustains one transfer
// per clock while rsp_ready stays high. The response register only holds
// while rsp_ready is low; req_ready then drops once the input register is
// also full. Configuration (initial send sequence, local port) is written
// through cfg_we/cfg_index/cfg_wdata; the user must do so only while no
// transfer is in flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module tcp_passive_endpoint_fsm (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// request channel
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire tpe_pkg::tpe_req_t            req,
	// response channel
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output tpe_pkg::tpe_rsp_t                 rsp,
	// configuration write port
	input  wire logic                         cfg_we,
	input  wire tpe_pkg::tpe_cfg_idx_t        cfg_index,
	input  wire logic [tpe_pkg::CFG_W-1:0]    cfg_wdata
);

	// configuration registers
	logic [tpe_pkg::SEQ_W-1:0]  initial_send_seq_q;
	logic [tpe_pkg::PORT_W-1:0] src_port_q;

	// input register stage
	logic                       valid_s1;
	tpe_pkg::tpe_req_t          req_s1;

	// response register stage
	logic                       valid_s2;
	tpe_pkg::tpe_rsp_t          rsp_s2;
	tpe_pkg::tpe_rsp_t          step_rsp;

	logic                       out_free;
	logic                       advance;

	// response register can take a new value when empty or being drained
	assign out_free  = !valid_s2 || rsp_ready;
	// the registered request moves into the response register this cycle
	assign advance   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_send_seq_q <= '0;
			src_port_q         <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tpe_pkg::CFG_INITIAL_SEND_SEQ: initial_send_seq_q <= cfg_wdata;
				tpe_pkg::CFG_LOCAL_PORT:       src_port_q <= cfg_wdata[tpe_pkg::PORT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// state update for the registered request, committed on advance
	tpe_conn u_conn (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_en          (advance),
		.item             (req_s1),
		.initial_send_seq (initial_send_seq_q),
		.src_port         (src_port_q),
		.result           (step_rsp)
	);

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= step_rsp;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule
`default_nettype wire

// ----- sim/tcp_passive_endpoint_fsm_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_passive_endpoint_fsm_tb
// self-checking bench for the passive tcp endpoint
// ----------------------------------------------------------------------------
// A directed opening walks a set of operations through every connection phase,
// with sequence numbers and configuration at their wrap points. Random phases
// then open, use and close connections over and over with random header
// content mixed with noise, under several configurations and idle patterns
// on both channels. Each accepted request is run through a local connection
// model and the predicted response is checked field by field against the
// response transfer that comes out in order.
// ----------------------------------------------------------------------------
module tcp_passive_endpoint_fsm_tb;
	import tpe_pkg::*;

	localparam int CLK_PERIOD      = 4;
	localparam int NUM_PHASES      = 6;
	localparam int ITEMS_PER_PHASE = 105;
	localparam int STALL_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 4;
	localparam int MAX_REPORTS     = 10;

	// connection context as the model tracks it
	typedef struct packed {
		logic [CODE_W-1:0] ph;
		logic [SEQ_W-1:0]  snd_nxt;
		logic [SEQ_W-1:0]  rcv_nxt;
		logic [PORT_W-1:0] peer_port;
		logic [ADDR_W-1:0] peer_addr;
	} conn_t;

	// request waiting to be driven; hold makes the driver wait for all
	// outstanding responses first
	typedef struct packed {
		logic     hold;
		tpe_req_t item;
	} backlog_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	tpe_req_t             req       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	tpe_rsp_t             rsp;
	logic                 cfg_we    = 1'b0;
	tpe_cfg_idx_t         cfg_index = CFG_INITIAL_SEND_SEQ;
	logic [CFG_W-1:0]     cfg_wdata = '0;

	// register values as last written
	logic [SEQ_W-1:0]     iss_cfg   = '0;
	logic [PORT_W-1:0]    lport_cfg = '0;

	// stimulus-side and checker-side copies of the connection
	conn_t                gen_conn  = '0;
	conn_t                chk_conn  = '0;

	backlog_t             req_backlog[$];
	tpe_rsp_t             rsp_due[$];

	logic                 req_xfer  = 1'b0;
	int                   req_idle_pct = 0;
	int                   rsp_idle_pct = 0;
	int                   mismatch_cnt = 0;
	int                   stall_cnt    = 0;

	tcp_passive_endpoint_fsm DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// ------------------------------------------------------------------------
	// connection model: next context and the response for one request
	// ------------------------------------------------------------------------
	function automatic conn_t step_conn(input conn_t c, input tpe_req_t r,
			input logic [SEQ_W-1:0] iss, input logic [PORT_W-1:0] lport,
			output tpe_rsp_t o);
		conn_t             n;
		logic              tx;
		logic [FLAG_W-1:0] fl;
		logic [SEQ_W-1:0]  sq;
		logic [SEQ_W-1:0]  ak;
		logic [LEN_W-1:0]  ln;
		logic              has_syn;
		logic              has_ack;
		logic              has_fin;
		n  = c;
		o  = '0;
		tx = 1'b0;
		fl = '0;
		sq = '0;
		ak = '0;
		ln = '0;
		has_syn = |(r.seg_flags & FLAG_SYN);
		has_ack = |(r.seg_flags & FLAG_ACK);
		has_fin = |(r.seg_flags & FLAG_FIN);
		case (r.op)
			OP_LISTEN: begin
				if (c.ph == CODE_CLOSED || c.ph > CODE_LAST_ACK)
					n.ph = CODE_LISTEN;
				else
					o.status = 1'b1;
			end
			OP_SEGMENT: begin
				case (c.ph)
					CODE_LISTEN: begin
						// opening syn: latch the peer, answer with syn-ack
						if (has_syn && !has_ack) begin
							n.peer_port = r.peer_port;
							n.peer_addr = r.peer_addr;
							n.rcv_nxt   = r.seg_seq + 32'd1;
							n.snd_nxt   = iss + 32'd1;
							n.ph        = CODE_SYN_RCVD;
							tx = 1'b1;
							fl = FLAG_SYN | FLAG_ACK;
							sq = iss;
							ak = n.rcv_nxt;
						end
					end
					CODE_SYN_RCVD: begin
						if (has_ack && r.seg_ack == c.snd_nxt)
							n.ph = CODE_ESTAB;
					end
					CODE_ESTAB: begin
						if (has_fin) begin
							// only an in-order fin closes the receive side
							if (r.seg_seq == c.rcv_nxt) begin
								n.rcv_nxt = c.rcv_nxt + 32'd1;
								n.ph      = CODE_CLOSE_WAIT;
								tx = 1'b1;
								fl = FLAG_ACK;
								sq = c.snd_nxt;
								ak = n.rcv_nxt;
							end
						end else if (r.payload_len != '0 && r.seg_seq == c.rcv_nxt) begin
							n.rcv_nxt   = c.rcv_nxt + SEQ_W'(r.payload_len);
							o.rx_accept = 1'b1;
							tx = 1'b1;
							fl = FLAG_ACK;
							sq = c.snd_nxt;
							ak = n.rcv_nxt;
						end
					end
					CODE_LAST_ACK: begin
						if (has_ack)
							n.ph = CODE_CLOSED;
					end
					default: ;
				endcase
			end
			OP_WRITE: begin
				if (c.ph == CODE_ESTAB) begin
					tx = 1'b1;
					fl = FLAG_ACK | FLAG_PSH;
					sq = c.snd_nxt;
					ak = c.rcv_nxt;
					ln = r.payload_len;
					n.snd_nxt = c.snd_nxt + SEQ_W'(r.payload_len);
				end else begin
					o.status = 1'b1;
				end
			end
			default: begin
				// close: quietly ignored outside the two open phases
				if (c.ph == CODE_ESTAB || c.ph == CODE_CLOSE_WAIT) begin
					tx = 1'b1;
					fl = FLAG_FIN | FLAG_ACK;
					sq = c.snd_nxt;
					ak = c.rcv_nxt;
					n.snd_nxt = c.snd_nxt + 32'd1;
					n.ph      = CODE_LAST_ACK;
				end
			end
		endcase
		// header fields stay zero when nothing goes out
		if (tx) begin
			o.send           = 1'b1;
			o.tx_flags       = fl;
			o.tx_seq         = sq;
			o.tx_ack         = ak;
			o.tx_src_port    = lport;
			o.tx_dst_port    = n.peer_port;
			o.tx_dst_addr    = n.peer_addr;
			o.tx_payload_len = ln;
		end
		o.conn_state = n.ph;
		return n;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic tpe_req_t mk_req(input tpe_op_t op, input logic [FLAG_W-1:0] fl,
			input logic [SEQ_W-1:0] sq, input logic [SEQ_W-1:0] ak,
			input logic [LEN_W-1:0] ln, input logic [PORT_W-1:0] pp,
			input logic [ADDR_W-1:0] pa);
		tpe_req_t r;
		r.op          = op;
		r.seg_flags   = fl;
		r.seg_seq     = sq;
		r.seg_ack     = ak;
		r.payload_len = ln;
		r.peer_port   = pp;
		r.peer_addr   = pa;
		return r;
	endfunction

	// queue a request and advance the stimulus-side connection; returns 1
	// when the request does something beyond being ignored or rejected
	function automatic bit add_item(input tpe_req_t r, input bit hold);
		tpe_rsp_t         o;
		logic [CODE_W-1:0] was;
		backlog_t         b;
		was    = gen_conn.ph;
		b.hold = hold;
		b.item = r;
		req_backlog.push_back(b);
		gen_conn = step_conn(gen_conn, r, iss_cfg, lport_cfg, o);
		return o.send || o.rx_accept || (o.conn_state != was);
	endfunction

	// mostly short payloads, with zero, the maximum and full-range values
	function automatic logic [LEN_W-1:0] rand_len();
		int roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		else if (roll < 4)
			return LEN_W'($urandom);
		return LEN_W'($urandom_range(1, 300));
	endfunction

	// pick the next request from the phase the connection will be in,
	// leaning toward well-formed steps with random content
	function automatic tpe_req_t pick_req();
		tpe_req_t r;
		int       roll;
		r.op          = tpe_op_t'($urandom_range(0, 3));
		r.seg_flags   = FLAG_W'($urandom);
		r.seg_seq     = ($urandom_range(0, 1) != 0) ? gen_conn.rcv_nxt : SEQ_W'($urandom);
		r.seg_ack     = ($urandom_range(0, 1) != 0) ? gen_conn.snd_nxt : SEQ_W'($urandom);
		r.payload_len = rand_len();
		r.peer_port   = PORT_W'($urandom);
		r.peer_addr   = ADDR_W'($urandom);
		roll = $urandom_range(0, 99);
		case (gen_conn.ph)
			CODE_CLOSED: begin
				if (roll < 80)
					r.op = OP_LISTEN;
			end
			CODE_LISTEN: begin
				if (roll < 75) begin
					r.op        = OP_SEGMENT;
					r.seg_flags = (r.seg_flags | FLAG_SYN) & ~FLAG_ACK;
				end
			end
			CODE_SYN_RCVD: begin
				if (roll < 75) begin
					r.op        = OP_SEGMENT;
					r.seg_flags = r.seg_flags | FLAG_ACK;
					r.seg_ack   = gen_conn.snd_nxt;
				end
			end
			CODE_ESTAB: begin
				if (roll < 35) begin
					// in-order data
					r.op        = OP_SEGMENT;
					r.seg_flags = r.seg_flags & ~FLAG_FIN;
					r.seg_seq   = gen_conn.rcv_nxt;
					if (r.payload_len == '0)
						r.payload_len = LEN_W'(1);
				end else if (roll < 55) begin
					r.op = OP_WRITE;
				end else if (roll < 62) begin
					// data just behind or ahead of the window edge
					r.op        = OP_SEGMENT;
					r.seg_flags = r.seg_flags & ~FLAG_FIN;
					r.seg_seq   = ($urandom_range(0, 1) != 0)
						? gen_conn.rcv_nxt + SEQ_W'($urandom_range(1, 100))
						: gen_conn.rcv_nxt - SEQ_W'($urandom_range(1, 100));
				end else if (roll < 67) begin
					r.op        = OP_SEGMENT;
					r.seg_flags = r.seg_flags | FLAG_FIN;
					r.seg_seq   = gen_conn.rcv_nxt + SEQ_W'($urandom_range(1, 3));
				end else if (roll < 73) begin
					r.op        = OP_SEGMENT;
					r.seg_flags = r.seg_flags | FLAG_FIN;
					r.seg_seq   = gen_conn.rcv_nxt;
				end else if (roll < 78) begin
					r.op = OP_CLOSE;
				end
			end
			CODE_CLOSE_WAIT: begin
				if (roll < 50)
					r.op = OP_CLOSE;
				else if (roll < 70)
					r.op = OP_WRITE;
			end
			CODE_LAST_ACK: begin
				if (roll < 70) begin
					r.op        = OP_SEGMENT;
					r.seg_flags = r.seg_flags | FLAG_ACK;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// walk each phase through a directed set of operations; expects iss all ones and
	// port all ones so the syn-ack sequence wraps
	task automatic run_directed();
		// closed: write rejected, close and segment ignored
		void'(add_item(mk_req(OP_WRITE, '0, '0, '0, 16'h0010, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_CLOSE, '0, '0, '0, '0, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_SEGMENT, '1, '0, '0, '0, '0, '0), 1'b0));
		// listen, then a second listen rejected
		void'(add_item(mk_req(OP_LISTEN, '0, '0, '0, '0, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_LISTEN, '0, '0, '0, '0, '0, '0), 1'b0));
		// syn with ack set and a flagless segment are ignored in listen
		void'(add_item(mk_req(OP_SEGMENT, FLAG_SYN | FLAG_ACK, 32'h1234, '0, '0,
			16'h0101, 32'h0a000001), 1'b0));
		void'(add_item(mk_req(OP_SEGMENT, '0, '0, '0, '0, '0, '0), 1'b0));
		// opening syn at the top of the sequence space, extreme peer fields
		void'(add_item(mk_req(OP_SEGMENT, ~FLAG_ACK, '1, '1, '1, '1, '1), 1'b0));
		// syn_received: listen and write rejected, close ignored
		void'(add_item(mk_req(OP_LISTEN, '0, '0, '0, '0, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_WRITE, '0, '0, '0, 16'h0001, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_CLOSE, '0, '0, '0, '0, '0, '0), 1'b0));
		// wrong ack number, then right number without the ack flag
		void'(add_item(mk_req(OP_SEGMENT, FLAG_ACK, '0, gen_conn.snd_nxt ^ 32'd1,
			'0, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_SEGMENT, ~FLAG_ACK, '0, gen_conn.snd_nxt,
			'0, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_SEGMENT, '1 & ~FLAG_FIN, '0, gen_conn.snd_nxt,
			'0, '0, '0), 1'b0));
		// established: largest in-order payload, then out-of-order and empty
		void'(add_item(mk_req(OP_SEGMENT, FLAG_ACK | FLAG_PSH, gen_conn.rcv_nxt, '0,
			'1, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_SEGMENT, FLAG_ACK, gen_conn.rcv_nxt + 32'd1, '0,
			16'd5, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_SEGMENT, FLAG_ACK, gen_conn.rcv_nxt, '0, '0,
			'0, '0), 1'b0));
		// fin out of order carrying payload: nothing accepted
		void'(add_item(mk_req(OP_SEGMENT, FLAG_FIN | FLAG_ACK, gen_conn.rcv_nxt - 32'd1,
			'0, 16'd10, '0, '0), 1'b0));
		// zero-length and maximum writes
		void'(add_item(mk_req(OP_WRITE, '0, '0, '0, '0, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_WRITE, '1, '1, '1, '1, '1, '1), 1'b0));
		// in-order fin moves to close_wait
		void'(add_item(mk_req(OP_SEGMENT, FLAG_FIN | FLAG_ACK, gen_conn.rcv_nxt, '0,
			'0, '0, '0), 1'b0));
		// close_wait: segments ignored, write rejected
		void'(add_item(mk_req(OP_SEGMENT, FLAG_ACK, gen_conn.rcv_nxt, '0, 16'd7,
			'0, '0), 1'b0));
		void'(add_item(mk_req(OP_WRITE, '0, '0, '0, 16'd3, '0, '0), 1'b0));
		// close, then only an ack finishes last_ack
		void'(add_item(mk_req(OP_CLOSE, '0, '0, '0, '0, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_SEGMENT, ~FLAG_ACK, '0, '0, '0, '0, '0), 1'b0));
		void'(add_item(mk_req(OP_SEGMENT, FLAG_ACK, '0, 32'hdead_beef, '0, '0, '0),
			1'b0));
	endtask

	task automatic run_random(input int target);
		int counted;
		bit hold;
		counted = 0;
		while (counted < target) begin
			// now and then the sender waits for every response to come back
			hold = (counted == 20) || ($urandom_range(0, 99) < 3);
			void'(add_item(pick_req(), hold));
			counted++;
		end
	endtask

	// wait for every queued request to go out and every response to come
	// back, then let the pipeline settle
	task automatic wait_drained();
		do
			@(negedge clk);
		while (req_backlog.size() != 0 || rsp_due.size() != 0 || req_valid);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(input tpe_cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == CFG_INITIAL_SEND_SEQ)
			iss_cfg = val;
		else
			lport_cfg = val[PORT_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// checking helpers
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_REPORTS)
				$display("%0t: %s mismatch: expected %h, actual %h", $realtime, name,
					want, got);
		end
	endtask

	task automatic compare_rsp(input tpe_rsp_t got, input tpe_rsp_t want);
		check_field("status",         32'(got.status),         32'(want.status));
		check_field("send",           32'(got.send),           32'(want.send));
		check_field("tx_flags",       32'(got.tx_flags),       32'(want.tx_flags));
		check_field("tx_seq",         got.tx_seq,              want.tx_seq);
		check_field("tx_ack",         got.tx_ack,              want.tx_ack);
		check_field("tx_src_port",    32'(got.tx_src_port),    32'(want.tx_src_port));
		check_field("tx_dst_port",    32'(got.tx_dst_port),    32'(want.tx_dst_port));
		check_field("tx_dst_addr",    got.tx_dst_addr,         want.tx_dst_addr);
		check_field("tx_payload_len", 32'(got.tx_payload_len), 32'(want.tx_payload_len));
		check_field("rx_accept",      32'(got.rx_accept),      32'(want.rx_accept));
		check_field("conn_state",     32'(got.conn_state),     32'(want.conn_state));
	endtask

	// ------------------------------------------------------------------------
	// request driver: changes inputs on the falling edge
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
			// a presented request stays put until its transfer happens
			if (!req_valid || req_xfer) begin
				if (req_backlog.size() != 0
						&& !(req_backlog[0].hold && rsp_due.size() != 0)
						&& $urandom_range(0, 99) >= req_idle_pct) begin
					req       <= req_backlog[0].item;
					req_valid <= 1'b1;
					void'(req_backlog.pop_front());
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: predicts on request transfers, checks response transfers
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : rsp_monitor
		tpe_rsp_t predicted;
		if (arst_n) begin
			req_xfer <= req_valid && req_ready;
			if (req_valid && req_ready) begin
				chk_conn = step_conn(chk_conn, req, iss_cfg, lport_cfg, predicted);
				rsp_due.push_back(predicted);
			end
			if (rsp_valid && rsp_ready) begin
				if (rsp_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("%0t: response transfer with none outstanding", $realtime);
				end else begin
					compare_rsp(rsp, rsp_due.pop_front());
				end
			end
			// watchdog on cycles without any transfer
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// sequencing: reset, then one configuration per phase
	// ------------------------------------------------------------------------
	initial begin : stimulus
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			case (p)
				0: begin
					// wrap the syn-ack sequence and use the top port
					write_cfg(CFG_INITIAL_SEND_SEQ, '1);
					write_cfg(CFG_LOCAL_PORT, 32'h0000_ffff);
				end
				1: begin
					write_cfg(CFG_INITIAL_SEND_SEQ, '0);
					write_cfg(CFG_LOCAL_PORT, '0);
				end
				3: begin
					write_cfg(CFG_INITIAL_SEND_SEQ, 32'hffff_fffe);
					write_cfg(CFG_LOCAL_PORT, 32'h0000_8000);
				end
				5: begin
					write_cfg(CFG_INITIAL_SEND_SEQ, 32'h7fff_ffff);
					write_cfg(CFG_LOCAL_PORT, 32'h0000_0001);
				end
				default: begin
					write_cfg(CFG_INITIAL_SEND_SEQ, $urandom);
					write_cfg(CFG_LOCAL_PORT, 32'($urandom_range(0, 65535)));
				end
			endcase
			// receiver mostly idle first, then sender, then neither
			if (p < 2) begin
				req_idle_pct = 9;
				rsp_idle_pct = 69;
			end else if (p < 4) begin
				req_idle_pct = 69;
				rsp_idle_pct = 9;
			end else begin
				req_idle_pct = 0;
				rsp_idle_pct = 0;
			end
			if (p == 0)
				run_directed();
			else
				run_random(ITEMS_PER_PHASE);
		end
		wait_drained();
		repeat (2 * DRAIN_CYCLES) @(negedge clk);
		if (mismatch_cnt == 0 && rsp_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/tpe_pkg.sv
sv/tpe_conn.sv
sv/tcp_passive_endpoint_fsm.sv
sim/tcp_passive_endpoint_fsm_tb.sv
